[src/rcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the RC servo PWM unit.
// No dependencies; used by every module of the block but rcs_div.
package rcs_pkg;

    localparam int DIV_W   = 24;
    localparam int WIDTH_W = 16;
    localparam int MUL_W   = DIV_W + 8;
    localparam int SCALE   = 100;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_SWEEP = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] CFG_ZERO_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FULL_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_FRAME_PERIOD  = 2'd2;
    localparam logic [1:0] CFG_RAMP_INTERVAL = 2'd3;

    localparam logic [WIDTH_W-1:0] RST_ZERO_WIDTH    = 16'd75;
    localparam logic [WIDTH_W-1:0] RST_FULL_WIDTH    = 16'd300;
    localparam logic [WIDTH_W-1:0] RST_FRAME_PERIOD  = 16'd2500;
    localparam logic [WIDTH_W-1:0] RST_RAMP_INTERVAL = 16'd1250;
    localparam logic [WIDTH_W-1:0] RST_WIDTH         = 16'd75;

    typedef struct packed {
        logic [WIDTH_W-1:0] zero_width;
        logic [WIDTH_W-1:0] full_width;
        logic [WIDTH_W-1:0] frame_period;
        logic [WIDTH_W-1:0] ramp_interval;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         action;
        logic [WIDTH_W-1:0] width;
    } t_q_item;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MOD,
        FS_DIVR,
        FS_MUL,
        FS_SCALE,
        FS_PUSH
    } t_front_state;

endpackage

[src/rc_servo_pwm_with_ramp_unit.sv]
`timescale 1ns / 1ps
// A tick or no-op enters the queue as it is accepted and its result is registered when the
// engine pops it; a set or sweep passes four conversion steps, the queue push and the engine
// update. Throughput: one tick per cycle while the queue has room; a command holds the input
// until it is pushed. Reset (i_rst_n low, synchronous): registers to defaults, width 75, low
// phase, no sweep. Depends on rcs_pkg, rcs_front, rcs_queue, rcs_back.
module rc_servo_pwm_with_ramp_unit #(
    parameter int DEGREE_RANGE = 135,
    parameter int TIMER_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_degrees,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pwm_out,
    output logic [15:0] o_pulse_width,
    output logic [15:0] o_target_width,
    output logic        o_ramping
);

    rcs_pkg::t_cfg    r_cfg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    rcs_pkg::t_q_item q_in_item;
    rcs_pkg::t_q_item q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_width    <= rcs_pkg::RST_ZERO_WIDTH;
            r_cfg.full_width    <= rcs_pkg::RST_FULL_WIDTH;
            r_cfg.frame_period  <= rcs_pkg::RST_FRAME_PERIOD;
            r_cfg.ramp_interval <= rcs_pkg::RST_RAMP_INTERVAL;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                rcs_pkg::CFG_ZERO_WIDTH:    r_cfg.zero_width    <= i_cfg_wdata;
                rcs_pkg::CFG_FULL_WIDTH:    r_cfg.full_width    <= i_cfg_wdata;
                rcs_pkg::CFG_FRAME_PERIOD:  r_cfg.frame_period  <= i_cfg_wdata;
                rcs_pkg::CFG_RAMP_INTERVAL: r_cfg.ramp_interval <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rcs_front #(
        .DEGREE_RANGE (DEGREE_RANGE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_degrees  (i_degrees),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    rcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    rcs_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pwm_out      (o_pwm_out),
        .o_pulse_width  (o_pulse_width),
        .o_target_width (o_target_width),
        .o_ramping      (o_ramping)
    );

endmodule

[src/rcs_div.sv]
`timescale 1ns / 1ps
// Unsigned division by a constant through reciprocal multiplication, combinational.
// No dependencies; used by the angle conversion in rcs_front.
module rcs_div #(
    parameter int N       = 8,
    parameter int DIVISOR = 1
) (
    input  logic [N-1:0] i_dividend,
    output logic [N-1:0] o_quot
);

    localparam int SH = N + $clog2(DIVISOR);
    localparam int PW = SH + N + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [PW-1:0] RECIP = PW'(RECIP_FULL);

    logic [PW-1:0] prod;

    assign prod   = PW'(i_dividend) * RECIP;
    assign o_quot = prod[SH +: N];

endmodule

[src/rcs_front.sv]
`timescale 1ns / 1ps
// Front end: accepts transactions, passes ticks and no-ops on, converts command angles to widths.
// Depends on rcs_pkg and rcs_div.
module rcs_front #(
    parameter int DEGREE_RANGE = 135
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcs_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic [7:0]                    i_degrees,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output rcs_pkg::t_q_item              o_q_item
);

    rcs_pkg::t_front_state r_state, n_state;
    logic [1:0]                   r_act, n_act;
    logic [7:0]                   r_deg, n_deg;
    logic [7:0]                   r_d, n_d;
    logic [rcs_pkg::DIV_W-1:0]    r_acc, n_acc;
    logic [rcs_pkg::WIDTH_W-1:0]  r_width, n_width;

    logic                         rising;
    logic [rcs_pkg::WIDTH_W-1:0]  span;
    logic [rcs_pkg::DIV_W-1:0]    span_x;
    logic [7:0]                   mod_quot;
    logic [16:0]                  mod_back;
    logic [rcs_pkg::DIV_W-1:0]    range_quot;
    logic [rcs_pkg::MUL_W-1:0]    mul_full;
    logic [rcs_pkg::DIV_W-1:0]    scale_quot;
    logic [rcs_pkg::WIDTH_W-1:0]  off;
    logic                         accept;
    logic                         is_cmd;

    assign rising   = i_cfg.full_width >= i_cfg.zero_width;
    assign span     = rising ? i_cfg.full_width - i_cfg.zero_width
                             : i_cfg.zero_width - i_cfg.full_width;
    assign span_x   = rcs_pkg::DIV_W'(span) * rcs_pkg::DIV_W'(rcs_pkg::SCALE);
    assign mod_back = 17'(mod_quot) * 17'(DEGREE_RANGE + 1);
    assign mul_full = rcs_pkg::MUL_W'(r_acc) * rcs_pkg::MUL_W'(r_d);
    assign off      = scale_quot[rcs_pkg::WIDTH_W-1:0];

    assign o_in_ready = (r_state == rcs_pkg::FS_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_cmd     = (i_action == rcs_pkg::ACT_SET) || (i_action == rcs_pkg::ACT_SWEEP);

    rcs_div #(
        .N       (8),
        .DIVISOR (DEGREE_RANGE + 1)
    ) u_mod (
        .i_dividend (r_deg),
        .o_quot     (mod_quot)
    );

    rcs_div #(
        .N       (rcs_pkg::DIV_W),
        .DIVISOR (DEGREE_RANGE)
    ) u_range (
        .i_dividend (r_acc),
        .o_quot     (range_quot)
    );

    rcs_div #(
        .N       (rcs_pkg::DIV_W),
        .DIVISOR (rcs_pkg::SCALE)
    ) u_scale (
        .i_dividend (r_acc),
        .o_quot     (scale_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_deg   <= n_deg;
        r_d     <= n_d;
        r_acc   <= n_acc;
        r_width <= n_width;
    end

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_deg    = r_deg;
        n_d      = r_d;
        n_acc    = r_acc;
        n_width  = r_width;
        o_q_push = 1'b0;
        o_q_item = '{action: r_act, width: r_width};
        unique case (r_state)
            rcs_pkg::FS_IDLE: begin
                if (accept) begin
                    if (is_cmd) begin
                        n_act   = i_action;
                        n_deg   = i_degrees;
                        n_state = rcs_pkg::FS_MOD;
                    end else begin
                        o_q_push = 1'b1;
                        o_q_item = '{action: i_action, width: '0};
                    end
                end
            end
            rcs_pkg::FS_MOD: begin
                n_d     = r_deg - mod_back[7:0];
                n_acc   = span_x;
                n_state = rcs_pkg::FS_DIVR;
            end
            rcs_pkg::FS_DIVR: begin
                n_acc   = range_quot;
                n_state = rcs_pkg::FS_MUL;
            end
            rcs_pkg::FS_MUL: begin
                n_acc   = mul_full[rcs_pkg::DIV_W-1:0];
                n_state = rcs_pkg::FS_SCALE;
            end
            rcs_pkg::FS_SCALE: begin
                n_width = rising ? i_cfg.zero_width + off : i_cfg.zero_width - off;
                n_state = rcs_pkg::FS_PUSH;
            end
            rcs_pkg::FS_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = rcs_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = rcs_pkg::FS_IDLE;
            end
        endcase
    end

endmodule

[src/rcs_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between the front end and the PWM engine.
// Depends on rcs_pkg for the entry type.
module rcs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rcs_pkg::t_q_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output rcs_pkg::t_q_item  o_head
);

    rcs_pkg::t_q_item r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[src/rcs_back.sv]
`timescale 1ns / 1ps
// PWM engine: ramp stepping, phase timing, command application and the result register.
// Depends on rcs_pkg; fed by rcs_queue.
module rcs_back #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcs_pkg::t_cfg                 i_cfg,
    input  logic                          i_q_empty,
    input  rcs_pkg::t_q_item              i_q_head,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_pwm_out,
    output logic [rcs_pkg::WIDTH_W-1:0]   o_pulse_width,
    output logic [rcs_pkg::WIDTH_W-1:0]   o_target_width,
    output logic                          o_ramping
);

    localparam int PH_W = (TIMER_WIDTH < rcs_pkg::WIDTH_W) ? TIMER_WIDTH : rcs_pkg::WIDTH_W;

    logic [rcs_pkg::WIDTH_W-1:0] r_width, n_width;
    logic [rcs_pkg::WIDTH_W-1:0] r_target, n_target;
    logic                        r_sweep, n_sweep;
    logic [rcs_pkg::WIDTH_W-1:0] r_rtl, n_rtl;
    logic                        r_high, n_high;
    logic [PH_W-1:0]             r_ptl, n_ptl;

    logic                        r_out_valid;
    logic                        r_out_pwm;
    logic [rcs_pkg::WIDTH_W-1:0] r_out_width;
    logic [rcs_pkg::WIDTH_W-1:0] r_out_target;
    logic                        r_out_ramping;

    logic [rcs_pkg::WIDTH_W-1:0] reload;
    logic [rcs_pkg::WIDTH_W-1:0] lo_full;
    logic [PH_W-1:0]             hi;
    logic [PH_W-1:0]             lo;
    logic [PH_W-1:0]             len;
    logic                        pop;

    assign pop     = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_q_pop = pop;
    assign reload  = (i_cfg.ramp_interval == '0) ? rcs_pkg::WIDTH_W'(1) : i_cfg.ramp_interval;

    always_comb begin
        n_width  = r_width;
        n_target = r_target;
        n_sweep  = r_sweep;
        n_rtl    = r_rtl;
        n_high   = r_high;
        n_ptl    = r_ptl;
        lo_full  = '0;
        hi       = '0;
        lo       = '0;
        len      = '0;
        unique case (i_q_head.action)
            rcs_pkg::ACT_TICK: begin
                if (r_sweep) begin
                    n_rtl = (r_rtl != '0) ? r_rtl - 1'b1 : '0;
                    if (n_rtl == '0) begin
                        if (r_width < r_target) begin
                            n_width = r_width + 1'b1;
                        end else if (r_width > r_target) begin
                            n_width = r_width - 1'b1;
                        end
                        if (n_width == r_target) begin
                            n_sweep = 1'b0;
                            n_rtl   = '0;
                        end else begin
                            n_rtl = reload;
                        end
                    end
                end
                lo_full = (i_cfg.frame_period > n_width) ? i_cfg.frame_period - n_width : '0;
                hi      = n_width[PH_W-1:0];
                lo      = lo_full[PH_W-1:0];
                if (r_ptl == '0) begin
                    if (!r_high) begin
                        if (hi != '0) begin
                            n_high = 1'b1;
                            len    = hi;
                        end else begin
                            len = lo;
                        end
                    end else begin
                        if (lo != '0) begin
                            n_high = 1'b0;
                            len    = lo;
                        end else begin
                            len = hi;
                        end
                    end
                    n_ptl = (len == '0) ? '0 : len - 1'b1;
                end else begin
                    n_ptl = r_ptl - 1'b1;
                end
            end
            rcs_pkg::ACT_SET: begin
                n_target = i_q_head.width;
                n_width  = i_q_head.width;
                n_sweep  = 1'b0;
                n_rtl    = '0;
            end
            rcs_pkg::ACT_SWEEP: begin
                n_target = i_q_head.width;
                if (i_q_head.width == r_width) begin
                    n_sweep = 1'b0;
                    n_rtl   = '0;
                end else begin
                    n_sweep = 1'b1;
                    n_rtl   = reload;
                end
            end
            rcs_pkg::ACT_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= rcs_pkg::RST_WIDTH;
            r_target    <= rcs_pkg::RST_WIDTH;
            r_sweep     <= 1'b0;
            r_rtl       <= '0;
            r_high      <= 1'b0;
            r_ptl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_width  <= n_width;
                r_target <= n_target;
                r_sweep  <= n_sweep;
                r_rtl    <= n_rtl;
                r_high   <= n_high;
                r_ptl    <= n_ptl;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_pwm     <= n_high;
            r_out_width   <= n_width;
            r_out_target  <= n_target;
            r_out_ramping <= n_sweep;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pwm_out      = r_out_pwm;
    assign o_pulse_width  = r_out_width;
    assign o_target_width = r_out_target;
    assign o_ramping      = r_out_ramping;

`ifndef SYNTHESIS
    a_sweep_not_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> (r_width != r_target))
        else $error("sweep active while width already at target");

    a_idle_ramp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sweep |-> (r_rtl == '0))
        else $error("ramp counter running without a sweep");

    a_sweep_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> (r_rtl != '0))
        else $error("sweep active with an expired ramp counter");

    a_set_stops_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_q_head.action == rcs_pkg::ACT_SET)) |=> (!r_sweep && r_width == r_target))
        else $error("set command left a sweep running");
`endif

endmodule
